[design/sab_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sab_pkg
// Shared constants, command codes and control structs of the suffix
// automaton builder.
// ---------------------------------------------------------------------------
package sab_pkg;

	localparam int MAX_TEXT_DEF = 32767;
	localparam int ALPHABET_DEF = 26;
	localparam int SYM_W        = 5;
	localparam int OUT_W        = 16;

	// datapath commands, one per controller state
	localparam logic [3:0] OP_IDLE   = 4'd0;
	localparam logic [3:0] OP_INIT   = 4'd1;
	localparam logic [3:0] OP_START  = 4'd2;
	localparam logic [3:0] OP_WALK   = 4'd3;
	localparam logic [3:0] OP_QCHK   = 4'd4;
	localparam logic [3:0] OP_CLONE2 = 4'd5;
	localparam logic [3:0] OP_CLONE3 = 4'd6;
	localparam logic [3:0] OP_REDIR  = 4'd7;
	localparam logic [3:0] OP_OUT    = 4'd8;

	typedef struct packed {
		logic [3:0] op;
		logic       accept;
		logic       out_load;
	} sab_cmd_t;

	typedef struct packed {
		logic drop;
		logic walk_empty;
		logic link_zero;
		logic len_ok;
		logic redir_hit;
		logic p_zero;
	} sab_sts_t;

endpackage

[design/sab_item_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sab_item_if
// Input channel: one symbol and a restart mark per beat.
// ---------------------------------------------------------------------------
interface sab_item_if import sab_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             restart;

	modport source (output valid, output symbol, output restart, input ready);
	modport sink   (input valid, input symbol, input restart, output ready);
endinterface

[design/sab_result_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sab_result_if
// Output channel: end state, its link, state count and drop flag per beat.
// ---------------------------------------------------------------------------
interface sab_result_if import sab_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] end_state;
	logic [OUT_W-1:0] end_link;
	logic [OUT_W-1:0] states_used;
	logic             dropped;

	modport source (output valid, output end_state, output end_link,
		output states_used, output dropped, input ready);
	modport sink   (input valid, input end_state, input end_link,
		input states_used, input dropped, output ready);
endinterface

[design/sab_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sab_ctrl
// Sequencer of one append: restart, new state, link walk, clone and
// redirect walk, then hand-off to the output register.
// ---------------------------------------------------------------------------
module sab_ctrl import sab_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	output logic     result_valid,
	input  logic     result_ready,
	input  sab_sts_t sts,
	output sab_cmd_t cmd
);

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign item_ready   = (state_q == OP_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || result_ready;

	always_comb begin
		cmd.op       = state_q;
		cmd.accept   = item_valid && (state_q == OP_IDLE);
		cmd.out_load = (state_q == OP_OUT) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			OP_IDLE:   if (item_valid) state_d = OP_INIT;
			OP_INIT:   state_d = OP_START;
			OP_START:  state_d = sts.drop ? OP_OUT : OP_WALK;
			OP_WALK: begin
				if (!sts.walk_empty)    state_d = OP_QCHK;
				else if (sts.link_zero) state_d = OP_OUT;
			end
			OP_QCHK:   state_d = sts.len_ok ? OP_OUT : OP_CLONE2;
			OP_CLONE2: state_d = OP_CLONE3;
			OP_CLONE3: state_d = sts.p_zero ? OP_OUT : OP_REDIR;
			OP_REDIR: begin
				if (!sts.redir_hit || sts.link_zero) state_d = OP_OUT;
			end
			OP_OUT:    if (out_free) state_d = OP_IDLE;
			default:   state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= OP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)      out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

[design/sab_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sab_dp
// Datapath: transition rows, suffix links and lengths in memories, the
// walk registers and the result register.
// ---------------------------------------------------------------------------
module sab_dp import sab_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sab_cmd_t         cmd,
	output sab_sts_t         sts,
	input  logic [SYM_W-1:0] symbol,
	input  logic             restart,
	output logic [OUT_W-1:0] end_state,
	output logic [OUT_W-1:0] end_link,
	output logic [OUT_W-1:0] states_used,
	output logic             dropped
);

	localparam int NST = 2 * MAX_TEXT + 2;
	localparam int SW  = $clog2(NST);
	localparam int LW  = $clog2(MAX_TEXT + 1);
	localparam int CW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

	typedef logic [ALPHABET-1:0][SW-1:0] row_t;

	localparam logic [SW-1:0] ROOT = SW'(1);

	// memories
	row_t          trans_mem [NST];
	logic [SW-1:0] link_mem  [NST];
	logic [LW-1:0] len_mem   [NST];

	row_t          row_rd_q;
	logic [SW-1:0] link_rd_q;
	logic [LW-1:0] len_rd_q;

	// control registers
	logic [SW-1:0]    last_q, cnt_q, end_link_q;
	logic [LW-1:0]    tlen_q;
	logic             need_init_q;
	// working registers
	logic [SYM_W-1:0] sym_q;
	logic             rst_q, drop_q;
	logic [SW-1:0]    p_q, np_q, q_q, nq_q, linkp_q;
	logic [LW-1:0]    lenp_q;
	row_t             rowp_q;
	// result register
	logic [OUT_W-1:0] res_state_q, res_link_q, res_cnt_q;
	logic             res_drop_q;

	logic [CW-1:0]    c;
	logic [SW-1:0]    rd_addr;
	logic             tw_en, lw_en, nw_en;
	logic [SW-1:0]    tw_addr, lw_addr, nw_addr, lw_data;
	logic [LW-1:0]    nw_data;
	row_t             tw_data;
	logic             drop_now;
	logic [SW-1:0]    row_c;

	assign c        = sym_q[CW-1:0];
	assign row_c    = row_rd_q[c];
	assign drop_now = (sym_q >= SYM_W'(ALPHABET)) || (tlen_q == LW'(MAX_TEXT));

	always_comb begin
		sts.drop       = drop_now;
		sts.walk_empty = (row_c == '0);
		sts.link_zero  = (link_rd_q == '0);
		sts.len_ok     = (len_rd_q == lenp_q + LW'(1));
		sts.redir_hit  = (row_c == q_q);
		sts.p_zero     = (p_q == '0);
	end

	// memory port control
	always_comb begin
		rd_addr = p_q;
		tw_en   = 1'b0;
		tw_addr = p_q;
		tw_data = row_rd_q;
		lw_en   = 1'b0;
		lw_addr = np_q;
		lw_data = ROOT;
		nw_en   = 1'b0;
		nw_addr = np_q;
		nw_data = tlen_q + LW'(1);
		case (cmd.op)
			OP_INIT: begin
				if (rst_q || need_init_q) begin
					tw_en   = 1'b1;
					tw_addr = ROOT;
					tw_data = '0;
					lw_en   = 1'b1;
					lw_addr = ROOT;
					lw_data = '0;
					nw_en   = 1'b1;
					nw_addr = ROOT;
					nw_data = '0;
				end
			end
			OP_START: begin
				rd_addr = last_q;
				if (!drop_now) begin
					tw_en   = 1'b1;
					tw_addr = cnt_q + SW'(1);
					tw_data = '0;
					nw_en   = 1'b1;
					nw_addr = cnt_q + SW'(1);
				end
			end
			OP_WALK: begin
				if (row_c == '0) begin
					tw_en      = 1'b1;
					tw_data[c] = np_q;
					rd_addr    = link_rd_q;
					if (link_rd_q == '0) lw_en = 1'b1;
				end else begin
					rd_addr = row_c;
				end
			end
			OP_QCHK: begin
				if (len_rd_q == lenp_q + LW'(1)) begin
					lw_en   = 1'b1;
					lw_data = q_q;
				end else begin
					tw_en   = 1'b1;
					tw_addr = cnt_q + SW'(1);
					lw_en   = 1'b1;
					lw_addr = cnt_q + SW'(1);
					lw_data = link_rd_q;
					nw_en   = 1'b1;
					nw_addr = cnt_q + SW'(1);
					nw_data = lenp_q + LW'(1);
				end
			end
			OP_CLONE2: begin
				tw_en      = 1'b1;
				tw_data    = rowp_q;
				tw_data[c] = nq_q;
				lw_en      = 1'b1;
				lw_data    = nq_q;
			end
			OP_CLONE3: begin
				lw_en   = 1'b1;
				lw_addr = q_q;
				lw_data = nq_q;
			end
			OP_REDIR: begin
				if (row_c == q_q) begin
					tw_en      = 1'b1;
					tw_data[c] = nq_q;
					rd_addr    = link_rd_q;
				end
			end
			default: ;
		endcase
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (tw_en) trans_mem[tw_addr] <= tw_data;
		if (lw_en) link_mem[lw_addr]  <= lw_data;
		if (nw_en) len_mem[nw_addr]   <= nw_data;
		row_rd_q  <= trans_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
		len_rd_q  <= len_mem[rd_addr];
	end

	// automaton control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= ROOT;
			cnt_q       <= ROOT;
			tlen_q      <= '0;
			end_link_q  <= '0;
			need_init_q <= 1'b1;
		end else begin
			case (cmd.op)
				OP_INIT: begin
					if (rst_q || need_init_q) begin
						last_q      <= ROOT;
						cnt_q       <= ROOT;
						tlen_q      <= '0;
						end_link_q  <= '0;
						need_init_q <= 1'b0;
					end
				end
				OP_START: begin
					if (!drop_now) begin
						cnt_q  <= cnt_q + SW'(1);
						last_q <= cnt_q + SW'(1);
						tlen_q <= tlen_q + LW'(1);
					end
				end
				OP_WALK: begin
					if (row_c == '0 && link_rd_q == '0) end_link_q <= ROOT;
				end
				OP_QCHK: begin
					if (len_rd_q == lenp_q + LW'(1)) end_link_q <= q_q;
					else cnt_q <= cnt_q + SW'(1);
				end
				OP_CLONE2: end_link_q <= nq_q;
				default: ;
			endcase
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q <= symbol;
			rst_q <= restart;
		end
		case (cmd.op)
			OP_START: begin
				drop_q <= drop_now;
				p_q    <= last_q;
				np_q   <= cnt_q + SW'(1);
			end
			OP_WALK: begin
				if (row_c == '0) begin
					p_q <= link_rd_q;
				end else begin
					q_q     <= row_c;
					lenp_q  <= len_rd_q;
					rowp_q  <= row_rd_q;
					linkp_q <= link_rd_q;
				end
			end
			OP_QCHK:   nq_q <= cnt_q + SW'(1);
			OP_CLONE2: p_q  <= linkp_q;
			OP_REDIR:  if (row_c == q_q) p_q <= link_rd_q;
			default: ;
		endcase
		if (cmd.out_load) begin
			res_state_q <= OUT_W'(last_q);
			res_link_q  <= OUT_W'(end_link_q);
			res_cnt_q   <= OUT_W'(cnt_q);
			res_drop_q  <= drop_q;
		end
	end

	assign end_state   = res_state_q;
	assign end_link    = res_link_q;
	assign states_used = res_cnt_q;
	assign dropped     = res_drop_q;

endmodule

[design/suffix_automaton_builder.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton over a small alphabet, one symbol per beat.
// ---------------------------------------------------------------------------
// Usage:
//   item   : one beat per symbol (symbol 0..ALPHABET-1, restart mark).
//   result : one beat per item: end state, its suffix link, states in use
//            and a drop flag (symbol out of range or text full).
// Sequence, from the accepted item to the load of the result: INIT and
//   START, then OUT for a dropped symbol; otherwise the update walk visits
//   one state per step, a length check (QCHK) follows when the walk meets
//   an existing transition, and a clone adds the CLONE2 and CLONE3 steps
//   and the redirect walk over the states it visits. Walks are amortized
//   about one state per symbol. Each state visited is read through the
//   registered read port.
// Throughput: one item at a time; the next item is taken as soon as the
//   previous result sits in the output register.
// Reset: the automaton is the lone root; the root entries are written with
//   the first item, so no memory pass is needed.
// A stalled receiver holds the result register; the sequencer waits before
//   loading the following result and meanwhile takes no further item.
// ---------------------------------------------------------------------------
module suffix_automaton_builder import sab_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF,
	parameter int ALPHABET = ALPHABET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sab_item_if.sink    item,
	sab_result_if.source result
);

	sab_cmd_t cmd;
	sab_sts_t sts;

	sab_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	sab_dp #(
		.MAX_TEXT (MAX_TEXT),
		.ALPHABET (ALPHABET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.symbol      (item.symbol),
		.restart     (item.restart),
		.end_state   (result.end_state),
		.end_link    (result.end_link),
		.states_used (result.states_used),
		.dropped     (result.dropped)
	);

endmodule
